@@ sv/vector3_fixed_point_alu_macros.svh @@
// Assertion helpers for the checker file of the vector ALU.
// Every property is clocked on clk and switched off while rst_n is low.
`ifndef VECTOR3_FIXED_POINT_ALU_MACROS_SVH
`define VECTOR3_FIXED_POINT_ALU_MACROS_SVH

// Same-cycle implication.
`define VFA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector ALU check failed");

// Next-cycle implication.
`define VFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector ALU check failed");

`endif

@@ sv/vfa_pkg.sv @@
// ----------------------------------------------------------------------------
// vfa_pkg
// Shared widths, opcodes, fault codes, pipeline records and the saturation
// helper for the 3D vector fixed point ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vfa_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SAT_BITS  = 2 * WORD_BITS + 2;
    localparam int RAD_BITS  = 2 * WORD_BITS;
    localparam int ROOT_BITS = WORD_BITS;
    localparam int SQ_STEPS  = ROOT_BITS;
    localparam int DVD_BITS  = WORD_BITS + FRAC_BITS;
    localparam int DIV_STEPS = DVD_BITS;

    typedef logic [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_ADD_S     = 4'd0,
        OP_SUB_S     = 4'd1,
        OP_MUL_S     = 4'd2,
        OP_DIV_S     = 4'd3,
        OP_ADD_V     = 4'd4,
        OP_SUB_V     = 4'd5,
        OP_MUL_V     = 4'd6,
        OP_DIV_V     = 4'd7,
        OP_NORM      = 4'd8,
        OP_NORMALIZE = 4'd9,
        OP_DOT       = 4'd10,
        OP_CROSS     = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_DIV_ZERO = 2'd1,
        FAULT_OVERFLOW = 2'd2
    } fault_t;

    // Operands and partial results that ride along the whole pipeline.
    typedef struct packed {
        logic [3:0]  func;
        word_t [2:0] a;
        word_t [2:0] dsr;
        word_t [2:0] r;
        word_t       rs;
        logic        ovf;
    } side_t;

    typedef struct packed {
        side_t                       side;
        logic [2:0][PROD_BITS-1:0]   p0;
        logic [2:0][PROD_BITS-1:0]   p1;
    } s1_t;

    typedef struct packed {
        side_t                       side;
        logic [2:0][PROD_BITS-1:0]   p0;
        logic [2:0][SAT_BITS-1:0]    c;
        logic [SAT_BITS-1:0]         tot;
    } s2_t;

    typedef struct packed {
        side_t                 side;
        logic [RAD_BITS-1:0]   rad;
        logic [ROOT_BITS+1:0]  rem;
        logic [ROOT_BITS-1:0]  root;
    } sq_t;

    typedef struct packed {
        side_t                     side;
        logic [2:0][DVD_BITS-1:0]  dvd;
        word_t [2:0]               rem;
        word_t [2:0]               md;
        logic [2:0]                qneg;
        logic [2:0]                dz;
        word_t [2:0]               dzval;
    } dv_t;

    typedef struct packed {
        logic  ovf;
        word_t val;
    } sat_t;

    function automatic sat_t sat_to_word(input logic signed [SAT_BITS-1:0] v);
        sat_t res;
        if (v[SAT_BITS-1:WORD_BITS-1] == {(SAT_BITS-WORD_BITS+1){v[SAT_BITS-1]}}) begin
            res.ovf = 1'b0;
            res.val = v[WORD_BITS-1:0];
        end
        else begin
            res.ovf = 1'b1;
            res.val = v[SAT_BITS-1] ? WORD_MIN : WORD_MAX;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ sv/vfa_sqrt_stage.sv @@
// ----------------------------------------------------------------------------
// vfa_sqrt_stage
// One registered step of the square root: retires one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vfa_sqrt_stage
    import vfa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_v,
    input  wire sq_t  in_d,
    output logic      out_v,
    output sq_t       out_d
);

    logic out_v_reg;
    sq_t  out_d_reg;
    sq_t  out_d_next;

    logic [ROOT_BITS+3:0] work;
    logic [ROOT_BITS+3:0] trial;
    logic [ROOT_BITS+3:0] diff;
    logic                 ge;

    always_comb
    begin
        work  = {in_d.rem, in_d.rad[RAD_BITS-1:RAD_BITS-2]};
        trial = {2'b00, in_d.root, 2'b01};
        diff  = work - trial;
        ge    = (work >= trial);
        out_d_next      = in_d;
        out_d_next.rad  = {in_d.rad[RAD_BITS-3:0], 2'b00};
        out_d_next.rem  = ge ? diff[ROOT_BITS+1:0] : work[ROOT_BITS+1:0];
        out_d_next.root = {in_d.root[ROOT_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_d_reg <= out_d_next;
        end
    end

    assign out_v = out_v_reg;
    assign out_d = out_d_reg;

endmodule

`default_nettype wire

@@ sv/vfa_div_stage.sv @@
// ----------------------------------------------------------------------------
// vfa_div_stage
// One registered restoring division step for all three lanes: one quotient
// bit per lane per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vfa_div_stage
    import vfa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_v,
    input  wire dv_t  in_d,
    output logic      out_v,
    output dv_t       out_d
);

    logic out_v_reg;
    dv_t  out_d_reg;
    dv_t  out_d_next;

    logic [WORD_BITS:0] work [3];
    logic [WORD_BITS:0] diff [3];
    logic [2:0]         ge;

    always_comb
    begin
        out_d_next = in_d;
        for (int k = 0; k < 3; k++)
        begin
            work[k] = {in_d.rem[k], in_d.dvd[k][DVD_BITS-1]};
            diff[k] = work[k] - {1'b0, in_d.md[k]};
            ge[k]   = (work[k] >= {1'b0, in_d.md[k]});
            out_d_next.rem[k] = ge[k] ? diff[k][WORD_BITS-1:0] : work[k][WORD_BITS-1:0];
            out_d_next.dvd[k] = {in_d.dvd[k][DVD_BITS-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_d_reg <= out_d_next;
        end
    end

    assign out_v = out_v_reg;
    assign out_d = out_d_reg;

endmodule

`default_nettype wire

@@ sv/vector3_fixed_point_alu.sv @@
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu
// Pipelined 3D vector ALU in signed Q16.16: scalar and element-wise add, sub,
// mul and div, length, normalize, dot and cross product, with saturation.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   input     in_valid / in_ready  func, ax, ay, az, bx, by, bz, scalar
//   output    out_valid/ out_ready rx, ry, rz, rs, fault
//
// One request is taken every cycle unless the output is held. Each request
// spends 85 register stages from acceptance to the output register: three
// for the multipliers, the sums and saturation, 32 for the square root (one
// root bit per stage), one to set up division, 48 for the three dividers
// (one quotient bit per stage) and one final saturation stage. Every opcode
// follows the same path. Reset clears only the valid bits. When the output
// is held, the whole pipeline stalls unless the output register is empty,
// so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module vector3_fixed_point_alu
    import vfa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [3:0]           func,
    input  wire logic [WORD_BITS-1:0] ax,
    input  wire logic [WORD_BITS-1:0] ay,
    input  wire logic [WORD_BITS-1:0] az,
    input  wire logic [WORD_BITS-1:0] bx,
    input  wire logic [WORD_BITS-1:0] by,
    input  wire logic [WORD_BITS-1:0] bz,
    input  wire logic [WORD_BITS-1:0] scalar,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [WORD_BITS-1:0]      rx,
    output logic [WORD_BITS-1:0]      ry,
    output logic [WORD_BITS-1:0]      rz,
    output logic [WORD_BITS-1:0]      rs,
    output logic [1:0]                fault
);

    // The pipeline moves as one: it advances whenever the output register
    // is free or is being emptied this cycle.
    logic adv;
    logic out_valid_reg;

    assign adv      = out_ready | ~out_valid_reg;
    assign in_ready = adv;

    // ------------------------------------------------------------------
    // Stage 1: operand selection and the six multipliers, add and subtract.
    // ------------------------------------------------------------------
    word_t av [3];
    word_t bv [3];
    word_t ar1 [3];
    word_t ar2 [3];
    word_t br1 [3];
    word_t br2 [3];

    assign av[0] = ax;
    assign av[1] = ay;
    assign av[2] = az;
    assign bv[0] = bx;
    assign bv[1] = by;
    assign bv[2] = bz;

    // Cyclic neighbours for the cross product.
    assign ar1[0] = ay;
    assign ar1[1] = az;
    assign ar1[2] = ax;
    assign ar2[0] = az;
    assign ar2[1] = ax;
    assign ar2[2] = ay;
    assign br1[0] = by;
    assign br1[1] = bz;
    assign br1[2] = bx;
    assign br2[0] = bz;
    assign br2[1] = bx;
    assign br2[2] = by;

    logic signed [WORD_BITS-1:0] m0a [3];
    logic signed [WORD_BITS-1:0] m0b [3];
    logic signed [WORD_BITS-1:0] m1a [3];
    logic signed [WORD_BITS-1:0] m1b [3];
    logic signed [PROD_BITS-1:0] p0 [3];
    logic signed [PROD_BITS-1:0] p1 [3];
    logic signed [SAT_BITS-1:0]  addsub [3];
    sat_t                        as_sat [3];
    word_t                       opnd [3];
    logic                        is_add;
    logic                        is_sub;

    logic s1_v_reg;
    s1_t  s1_reg;
    s1_t  s1_next;

    always_comb
    begin
        is_add = (func == OP_ADD_S) || (func == OP_ADD_V);
        is_sub = (func == OP_SUB_S) || (func == OP_SUB_V);
        s1_next.side.func = func;
        s1_next.side.rs   = '0;
        s1_next.side.ovf  = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            unique case (func)
                OP_CROSS:
                begin
                    m0a[k] = ar1[k];
                    m0b[k] = br2[k];
                    m1a[k] = ar2[k];
                    m1b[k] = br1[k];
                end
                OP_MUL_S:
                begin
                    m0a[k] = av[k];
                    m0b[k] = scalar;
                    m1a[k] = '0;
                    m1b[k] = '0;
                end
                OP_NORM, OP_NORMALIZE:
                begin
                    m0a[k] = av[k];
                    m0b[k] = av[k];
                    m1a[k] = '0;
                    m1b[k] = '0;
                end
                default:
                begin
                    m0a[k] = av[k];
                    m0b[k] = bv[k];
                    m1a[k] = '0;
                    m1b[k] = '0;
                end
            endcase
            p0[k] = PROD_BITS'(m0a[k]) * PROD_BITS'(m0b[k]);
            p1[k] = PROD_BITS'(m1a[k]) * PROD_BITS'(m1b[k]);

            opnd[k] = (func < OP_ADD_V) ? scalar : bv[k];
            if (is_sub)
            begin
                addsub[k] = SAT_BITS'($signed(av[k])) - SAT_BITS'($signed(opnd[k]));
            end
            else
            begin
                addsub[k] = SAT_BITS'($signed(av[k])) + SAT_BITS'($signed(opnd[k]));
            end
            as_sat[k] = sat_to_word(addsub[k]);

            s1_next.side.a[k]   = av[k];
            s1_next.side.dsr[k] = opnd[k];
            s1_next.p0[k]       = p0[k];
            s1_next.p1[k]       = p1[k];
            if (is_add || is_sub)
            begin
                s1_next.side.r[k] = as_sat[k].val;
                s1_next.side.ovf  = s1_next.side.ovf | as_sat[k].ovf;
            end
            else
            begin
                s1_next.side.r[k] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cross differences and the three-term sum for dot and length.
    // ------------------------------------------------------------------
    logic s2_v_reg;
    s2_t  s2_reg;
    s2_t  s2_next;

    always_comb
    begin
        s2_next.side = s1_reg.side;
        s2_next.p0   = s1_reg.p0;
        for (int k = 0; k < 3; k++)
        begin
            s2_next.c[k] = SAT_BITS'($signed(s1_reg.p0[k]))
                         - SAT_BITS'($signed(s1_reg.p1[k]));
        end
        s2_next.tot = SAT_BITS'($signed(s1_reg.p0[0]))
                    + SAT_BITS'($signed(s1_reg.p0[1]))
                    + SAT_BITS'($signed(s1_reg.p0[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg <= s2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: drop the extra fraction bits (floor) and saturate products;
    // the sum of squares becomes the radicand.
    // ------------------------------------------------------------------
    logic signed [SAT_BITS-1:0] mul_sh [3];
    logic signed [SAT_BITS-1:0] crs_sh [3];
    logic signed [SAT_BITS-1:0] dot_sh;
    sat_t                       mul_sat [3];
    sat_t                       crs_sat [3];
    sat_t                       dot_sat;

    logic s3_v_reg;
    sq_t  s3_reg;
    sq_t  s3_next;

    always_comb
    begin
        s3_next.side = s2_reg.side;
        s3_next.rad  = s2_reg.tot[RAD_BITS-1:0];
        s3_next.rem  = '0;
        s3_next.root = '0;
        dot_sh  = $signed(s2_reg.tot) >>> FRAC_BITS;
        dot_sat = sat_to_word(dot_sh);
        for (int k = 0; k < 3; k++)
        begin
            mul_sh[k]  = SAT_BITS'($signed(s2_reg.p0[k])) >>> FRAC_BITS;
            crs_sh[k]  = $signed(s2_reg.c[k]) >>> FRAC_BITS;
            mul_sat[k] = sat_to_word(mul_sh[k]);
            crs_sat[k] = sat_to_word(crs_sh[k]);
        end
        unique case (s2_reg.side.func)
            OP_MUL_S, OP_MUL_V:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s3_next.side.r[k] = mul_sat[k].val;
                    s3_next.side.ovf  = s3_next.side.ovf | mul_sat[k].ovf;
                end
            end
            OP_CROSS:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s3_next.side.r[k] = crs_sat[k].val;
                    s3_next.side.ovf  = s3_next.side.ovf | crs_sat[k].ovf;
                end
            end
            OP_DOT:
            begin
                s3_next.side.rs  = dot_sat.val;
                s3_next.side.ovf = dot_sat.ovf;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg <= s3_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one stage per root bit.
    // ------------------------------------------------------------------
    logic sq_v [SQ_STEPS+1];
    sq_t  sq_d [SQ_STEPS+1];

    assign sq_v[0] = s3_v_reg;
    assign sq_d[0] = s3_reg;

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_sqrt
        vfa_sqrt_stage u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .in_v  (sq_v[g]),
            .in_d  (sq_d[g]),
            .out_v (sq_v[g+1]),
            .out_d (sq_d[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Division set-up: signs, magnitudes and the divide-by-zero values.
    // Normalize divides by the length just found.
    // ------------------------------------------------------------------
    sq_t                 sq_end;
    logic                is_nrm;
    logic [2:0]          nn;
    logic [2:0]          nd;
    word_t               mn [3];

    logic su_v_reg;
    dv_t  su_reg;
    dv_t  su_next;

    always_comb
    begin
        sq_end       = sq_d[SQ_STEPS];
        is_nrm       = (sq_end.side.func == OP_NORMALIZE);
        su_next.side = sq_end.side;
        if (sq_end.side.func == OP_NORM)
        begin
            if (sq_end.root[ROOT_BITS-1])
            begin
                su_next.side.rs  = WORD_MAX;
                su_next.side.ovf = 1'b1;
            end
            else
            begin
                su_next.side.rs = sq_end.root;
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            nn[k] = sq_end.side.a[k][WORD_BITS-1];
            nd[k] = ~is_nrm & sq_end.side.dsr[k][WORD_BITS-1];
            mn[k] = nn[k] ? (word_t'(0) - sq_end.side.a[k]) : sq_end.side.a[k];
            if (is_nrm)
            begin
                su_next.md[k] = sq_end.root;
            end
            else
            begin
                su_next.md[k] = nd[k] ? (word_t'(0) - sq_end.side.dsr[k])
                                      : sq_end.side.dsr[k];
            end
            su_next.dvd[k]  = {mn[k], {FRAC_BITS{1'b0}}};
            su_next.rem[k]  = '0;
            su_next.qneg[k] = nn[k] ^ nd[k];
            su_next.dz[k]   = (su_next.md[k] == '0);
            if (sq_end.side.a[k] == '0)
            begin
                su_next.dzval[k] = '0;
            end
            else
            begin
                su_next.dzval[k] = nn[k] ? WORD_MIN : WORD_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            su_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            su_v_reg <= sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            su_reg <= su_next;
        end
    end

    // ------------------------------------------------------------------
    // Three dividers side by side, one quotient bit per stage.
    // ------------------------------------------------------------------
    logic dv_v [DIV_STEPS+1];
    dv_t  dv_d [DIV_STEPS+1];

    assign dv_v[0] = su_v_reg;
    assign dv_d[0] = su_reg;

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        vfa_div_stage u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .in_v  (dv_v[g]),
            .in_d  (dv_d[g]),
            .out_v (dv_v[g+1]),
            .out_d (dv_d[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Final stage: quotient sign and saturation, fault code, output register.
    // A divide by zero outranks an overflow.
    // ------------------------------------------------------------------
    localparam logic [DVD_BITS-1:0] Q_POS_LIM = DVD_BITS'(WORD_MAX);
    localparam logic [DVD_BITS-1:0] Q_NEG_LIM = DVD_BITS'(WORD_MAX) + DVD_BITS'(1);

    dv_t                 dv_end;
    logic                is_div;
    logic [DVD_BITS-1:0] qneg_val [3];
    word_t               fin_r [3];
    word_t               fin_rs;
    logic                fin_ovf;
    logic                fin_dz;
    fault_t              fin_fault;

    word_t  rx_reg;
    word_t  ry_reg;
    word_t  rz_reg;
    word_t  rs_reg;
    fault_t fault_reg;

    always_comb
    begin
        dv_end  = dv_d[DIV_STEPS];
        is_div  = (dv_end.side.func == OP_DIV_S) || (dv_end.side.func == OP_DIV_V)
               || (dv_end.side.func == OP_NORMALIZE);
        fin_rs  = dv_end.side.rs;
        fin_ovf = dv_end.side.ovf;
        fin_dz  = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            qneg_val[k] = DVD_BITS'(0) - dv_end.dvd[k];
            fin_r[k]    = dv_end.side.r[k];
            if (is_div)
            begin
                if (dv_end.dz[k])
                begin
                    fin_r[k] = dv_end.dzval[k];
                    fin_dz   = 1'b1;
                end
                else if (dv_end.qneg[k])
                begin
                    if (dv_end.dvd[k] > Q_NEG_LIM)
                    begin
                        fin_r[k] = WORD_MIN;
                        fin_ovf  = 1'b1;
                    end
                    else
                    begin
                        fin_r[k] = qneg_val[k][WORD_BITS-1:0];
                    end
                end
                else
                begin
                    if (dv_end.dvd[k] > Q_POS_LIM)
                    begin
                        fin_r[k] = WORD_MAX;
                        fin_ovf  = 1'b1;
                    end
                    else
                    begin
                        fin_r[k] = dv_end.dvd[k][WORD_BITS-1:0];
                    end
                end
            end
        end
        priority if (fin_dz)
        begin
            fin_fault = FAULT_DIV_ZERO;
        end
        else if (fin_ovf)
        begin
            fin_fault = FAULT_OVERFLOW;
        end
        else
        begin
            fin_fault = FAULT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_v[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg    <= fin_r[0];
            ry_reg    <= fin_r[1];
            rz_reg    <= fin_r[2];
            rs_reg    <= fin_rs;
            fault_reg <= fin_fault;
        end
    end

    assign out_valid = out_valid_reg;
    assign rx        = rx_reg;
    assign ry        = ry_reg;
    assign rz        = rz_reg;
    assign rs        = rs_reg;
    assign fault     = fault_reg;

endmodule

`default_nettype wire

@@ sv/vfa_checker.sv @@
// ----------------------------------------------------------------------------
// vfa_checker
// Port-level checks on the vector ALU, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "vector3_fixed_point_alu_macros.svh"

module vfa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] rx,
    input wire logic [31:0] ry,
    input wire logic [31:0] rz,
    input wire logic [31:0] rs,
    input wire logic [1:0]  fault
);

    // A held result keeps its value.
    `VFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rx) && $stable(ry) && $stable(rz) && $stable(rs) && $stable(fault))

    // The input side is only ever held back by a blocked output.
    `VFA_ASSERT_IMPL(a_ready_free, !out_valid || out_ready, in_ready)

    // A scalar result comes with a zero vector.
    `VFA_ASSERT_IMPL(a_scalar_zero_vec, out_valid && rs != 32'd0, rx == 32'd0 && ry == 32'd0 && rz == 32'd0)

    // An accepted request with the output blocked cannot be lost: the
    // output register must then be empty.
    `VFA_ASSERT_IMPL(a_accept_blocked, in_valid && in_ready && !out_ready, !out_valid)

endmodule

bind vector3_fixed_point_alu vfa_checker u_vfa_checker (.*);

`default_nettype wire

@@ verif/tb_vector3_fixed_point_alu.sv @@
// ----------------------------------------------------------------------------
// tb_vector3_fixed_point_alu
// Self-checking testbench for the pipelined 3D vector fixed point ALU: a
// table of directed requests followed by random traffic, each result checked
// against its known table entry or a behavioural wide-arithmetic predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vector3_fixed_point_alu;

    import vfa_pkg::*;

    localparam int          HALF_PERIOD  = 4;
    localparam int          RESET_CYCLES = 9;
    localparam int          RANDOM_ITEMS = 1400;
    localparam int          IDLE_LIMIT   = 5000;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          HOLD_AT      = 400;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PAUSE_AT     = 700;
    localparam logic [3:0]  OP_SPARE_LO  = 4'd12;
    localparam logic [3:0]  OP_SPARE_HI  = 4'd15;
    localparam word_t       Q_ONE        = 32'h0001_0000;
    localparam word_t       Q_HALF       = 32'h0000_8000;
    localparam word_t       Q_MINUS_ONE  = 32'hFFFF_0000;

    // One request as it goes into the block.
    typedef struct packed {
        logic [3:0]  func;
        word_t [2:0] a;
        word_t [2:0] b;
        word_t       s;
    } request_t;

    // One result as it comes out of the block.
    typedef struct packed {
        word_t [2:0] r;
        word_t       rs;
        logic [1:0]  fault;
    } vec_result_t;

    // A row of the directed table; the expected result is only filled in
    // where it is obvious by inspection.
    typedef struct packed {
        request_t    req;
        logic        known;
        vec_result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  func;
    word_t       ax, ay, az, bx, by, bz, scalar;
    logic        out_valid;
    logic        out_ready;
    word_t       rx, ry, rz, rs;
    logic [1:0]  fault;

    vec_result_t pending_results[$];
    stim_row_t   stim_table[$];
    int          mismatches;
    int          results_seen;
    int          idle_cycles;

    vector3_fixed_point_alu dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .ax        (ax),
        .ay        (ay),
        .az        (az),
        .bx        (bx),
        .by        (by),
        .bz        (bz),
        .scalar    (scalar),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rx        (rx),
        .ry        (ry),
        .rz        (rz),
        .rs        (rs),
        .fault     (fault)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor. Everything is carried in 128-bit signed words, so no
    // intermediate can overflow before the final saturation.
    // ------------------------------------------------------------------
    function automatic logic signed [127:0] widen(input word_t w);
        logic signed [127:0] v;
        v = $signed(w);
        return v;
    endfunction

    function automatic word_t clamp_word(input logic signed [127:0] v, inout bit ovf);
        if (v > widen(WORD_MAX)) begin
            ovf = 1'b1;
            return WORD_MAX;
        end
        if (v < widen(WORD_MIN)) begin
            ovf = 1'b1;
            return WORD_MIN;
        end
        return v[WORD_BITS-1:0];
    endfunction

    // Quotient (num << FRAC_BITS) / den, truncated toward zero. A zero divisor
    // saturates according to the sign of the numerator; a zero numerator gives zero.
    function automatic word_t fixed_quotient(input logic signed [127:0] num,
                                             input logic signed [127:0] den,
                                             inout bit dz, inout bit ovf);
        logic [127:0]        mag_n;
        logic [127:0]        mag_d;
        logic signed [127:0] quo;
        if (den == 0) begin
            dz = 1'b1;
            if (num == 0)
                return '0;
            return (num < 0) ? WORD_MIN : WORD_MAX;
        end
        mag_n = (num < 0) ? -num : num;
        mag_d = (den < 0) ? -den : den;
        quo   = $signed((mag_n << FRAC_BITS) / mag_d);
        if ((num < 0) != (den < 0))
            quo = -quo;
        return clamp_word(quo, ovf);
    endfunction

    // Floor of the square root of the exact sum of squares.
    function automatic logic signed [127:0] vector_length(input word_t [2:0] v);
        logic [127:0] sum;
        logic [127:0] root;
        logic [127:0] trial;
        sum  = widen(v[0]) * widen(v[0]) + widen(v[1]) * widen(v[1])
             + widen(v[2]) * widen(v[2]);
        root = '0;
        for (int bit_idx = 50; bit_idx >= 0; bit_idx--) begin
            trial = root | (128'd1 << bit_idx);
            if (trial * trial <= sum)
                root = trial;
        end
        return $signed(root);
    endfunction

    function automatic vec_result_t predict_alu(input request_t q);
        vec_result_t         res;
        bit                  dz;
        bit                  ovf;
        logic signed [127:0] lhs;
        logic signed [127:0] rhs;
        logic signed [127:0] len;
        logic signed [127:0] acc;
        res = '0;
        dz  = 1'b0;
        ovf = 1'b0;
        if (q.func <= OP_DIV_V) begin
            for (int k = 0; k < 3; k++) begin
                lhs = widen(q.a[k]);
                rhs = (q.func < OP_ADD_V) ? widen(q.s) : widen(q.b[k]);
                case (q.func[1:0])
                    2'd0:    res.r[k] = clamp_word(lhs + rhs, ovf);
                    2'd1:    res.r[k] = clamp_word(lhs - rhs, ovf);
                    2'd2:    res.r[k] = clamp_word((lhs * rhs) >>> FRAC_BITS, ovf);
                    default: res.r[k] = fixed_quotient(lhs, rhs, dz, ovf);
                endcase
            end
        end
        else if (q.func == OP_NORM) begin
            res.rs = clamp_word(vector_length(q.a), ovf);
        end
        else if (q.func == OP_NORMALIZE) begin
            len = vector_length(q.a);
            for (int k = 0; k < 3; k++)
                res.r[k] = fixed_quotient(widen(q.a[k]), len, dz, ovf);
        end
        else if (q.func == OP_DOT) begin
            acc = '0;
            for (int k = 0; k < 3; k++)
                acc += widen(q.a[k]) * widen(q.b[k]);
            res.rs = clamp_word(acc >>> FRAC_BITS, ovf);
        end
        else if (q.func == OP_CROSS) begin
            for (int k = 0; k < 3; k++) begin
                acc = widen(q.a[(k + 1) % 3]) * widen(q.b[(k + 2) % 3])
                    - widen(q.a[(k + 2) % 3]) * widen(q.b[(k + 1) % 3]);
                res.r[k] = clamp_word(acc >>> FRAC_BITS, ovf);
            end
        end
        res.fault = dz ? FAULT_DIV_ZERO : (ovf ? FAULT_OVERFLOW : FAULT_NONE);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Directed table.
    // ------------------------------------------------------------------
    task automatic add_row(input logic [3:0] f,
                           input word_t a0, input word_t a1, input word_t a2,
                           input word_t b0, input word_t b1, input word_t b2,
                           input word_t s, input logic known = 1'b0,
                           input word_t r0 = '0, input word_t r1 = '0,
                           input word_t r2 = '0, input word_t rsv = '0,
                           input logic [1:0] flt = FAULT_NONE);
        stim_row_t row;
        row.req   = '{func: f, a: '{a2, a1, a0}, b: '{b2, b1, b0}, s: s};
        row.known = known;
        row.res   = '{r: '{r2, r1, r0}, rs: rsv, fault: flt};
        stim_table.push_back(row);
    endtask

    task automatic build_table();
        add_row(OP_ADD_S, '0, '0, '0, '0, '0, '0, '0, 1'b1);
        add_row(OP_ADD_S, Q_ONE, Q_MINUS_ONE, '0, '0, '0, '0, Q_HALF);
        add_row(OP_ADD_S, WORD_MAX, WORD_MAX, WORD_MAX, '0, '0, '0, Q_ONE, 1'b1,
                WORD_MAX, WORD_MAX, WORD_MAX, '0, FAULT_OVERFLOW);
        add_row(OP_SUB_S, WORD_MIN, WORD_MIN, WORD_MIN, '0, '0, '0, Q_ONE, 1'b1,
                WORD_MIN, WORD_MIN, WORD_MIN, '0, FAULT_OVERFLOW);
        add_row(OP_MUL_S, 32'h0002_0000, 32'hFFFD_0000, Q_HALF, '0, '0, '0,
                32'h0001_8000);
        add_row(OP_MUL_S, WORD_MAX, WORD_MIN, WORD_MAX, '0, '0, '0, WORD_MAX);
        add_row(OP_DIV_S, Q_ONE, Q_MINUS_ONE, '0, '0, '0, '0, '0, 1'b1,
                WORD_MAX, WORD_MIN, '0, '0, FAULT_DIV_ZERO);
        add_row(OP_DIV_S, 32'h0003_0000, WORD_MIN, 32'd1, '0, '0, '0, 32'h0002_0000);
        add_row(OP_ADD_V, WORD_MAX, WORD_MIN, Q_ONE, WORD_MAX, WORD_MIN, Q_ONE, '0);
        add_row(OP_SUB_V, WORD_MIN, WORD_MAX, Q_ONE, WORD_MAX, WORD_MIN, Q_HALF, '0);
        add_row(OP_MUL_V, WORD_MIN, WORD_MAX, Q_HALF, WORD_MIN, Q_MINUS_ONE, Q_HALF, '0);
        add_row(OP_DIV_V, Q_ONE, 32'h0002_0000, Q_MINUS_ONE, '0, Q_ONE, 32'h0003_0000, '0);
        add_row(OP_DIV_V, WORD_MIN, WORD_MAX, 32'd1, Q_MINUS_ONE, 32'd1, WORD_MIN, '0);
        add_row(OP_NORM, 32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0, '0, 1'b1,
                '0, '0, '0, 32'h0005_0000, FAULT_NONE);
        add_row(OP_NORM, WORD_MIN, WORD_MIN, WORD_MIN, '0, '0, '0, '0);
        add_row(OP_NORMALIZE, '0, '0, '0, '0, '0, '0, '0, 1'b1,
                '0, '0, '0, '0, FAULT_DIV_ZERO);
        add_row(OP_NORMALIZE, 32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0, '0);
        add_row(OP_NORMALIZE, 32'd1, '0, '0, '0, '0, '0, '0);
        add_row(OP_NORMALIZE, WORD_MAX, WORD_MIN, WORD_MAX, '0, '0, '0, '0);
        add_row(OP_DOT, Q_ONE, 32'h0002_0000, Q_MINUS_ONE, Q_HALF, Q_ONE, Q_ONE, '0);
        add_row(OP_DOT, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, '0);
        add_row(OP_CROSS, Q_ONE, '0, '0, '0, Q_ONE, '0, '0, 1'b1,
                '0, '0, Q_ONE, '0, FAULT_NONE);
        add_row(OP_CROSS, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, '0);
        add_row(OP_SPARE_LO, WORD_MAX, WORD_MIN, Q_ONE, Q_ONE, WORD_MAX, '0, WORD_MIN,
                1'b1);
        add_row(OP_SPARE_HI, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random operands: a blend of zeros, extremes, full-range words and
    // small magnitudes, so that every operation meets its corner cases.
    // ------------------------------------------------------------------
    function automatic word_t random_word();
        logic [19:0] small_val;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return WORD_MAX;
            2:       return WORD_MIN;
            3, 4, 5: return $urandom;
            default: begin
                small_val = 20'($urandom);
                return {{12{small_val[19]}}, small_val};
            end
        endcase
    endfunction

    function automatic request_t random_request();
        request_t q;
        if ($urandom_range(0, 99) < 95)
            q.func = 4'($urandom_range(0, 11));
        else
            q.func = 4'($urandom_range(12, 15));
        for (int k = 0; k < 3; k++) begin
            q.a[k] = random_word();
            q.b[k] = random_word();
        end
        q.s = random_word();
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Sender: holds the request until it is taken, then records what the
    // block owes for it.
    // ------------------------------------------------------------------
    task automatic offer_request(input request_t q, input logic known,
                                 input vec_result_t res);
        in_valid <= 1'b1;
        func     <= q.func;
        ax       <= q.a[0];
        ay       <= q.a[1];
        az       <= q.a[2];
        bx       <= q.b[0];
        by       <= q.b[1];
        bz       <= q.b[2];
        scalar   <= q.s;
        forever
        begin
            @(posedge clk);
            if (in_valid && in_ready)
                break;
        end
        pending_results.push_back(known ? res : predict_alu(q));
    endtask

    task automatic sender_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 20);
    endtask

    task automatic wait_until_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int burst_left;
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = '0;
        ax            = '0;
        ay            = '0;
        az            = '0;
        bx            = '0;
        by            = '0;
        bz            = '0;
        scalar        = '0;
        mismatches    = 0;
        burst_left    = 0;
        build_table();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            sender_gap(burst_left);
            offer_request(stim_table[i].req, stim_table[i].known, stim_table[i].res);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sender_gap(burst_left);
            if (n == PAUSE_AT)
            begin
                // Let the pipeline run completely dry before carrying on.
                in_valid <= 1'b0;
                wait_until_drained();
                @(posedge clk);
            end
            offer_request(random_request(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: a changing back-pressure pattern, plus one long hold-off
    // that lets the pipeline fill and stall its input.
    // ------------------------------------------------------------------
    initial
    begin
        int cycle_count;
        int hold_left;
        bit hold_done;
        out_ready   = 1'b0;
        cycle_count = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case ((cycle_count / 97) % 4)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 9) < 7);
                    2:       out_ready <= ($urandom_range(0, 9) < 3);
                    default: out_ready <= (cycle_count % 3 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking and watchdog.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input word_t got, input word_t want);
        mismatches++;
        $display("%0t: result %0d field %s got %08h expected %08h",
                 $realtime, results_seen, field, got, want);
    endtask

    initial results_seen = 0;

    always @(posedge clk)
    begin
        vec_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no request outstanding", $realtime);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rx !== want.r[0]) report_mismatch("rx", rx, want.r[0]);
                if (ry !== want.r[1]) report_mismatch("ry", ry, want.r[1]);
                if (rz !== want.r[2]) report_mismatch("rz", rz, want.r[2]);
                if (rs !== want.rs)   report_mismatch("rs", rs, want.rs);
                if (fault !== want.fault)
                    report_mismatch("fault", {30'd0, fault}, {30'd0, want.fault});
            end
            results_seen++;
        end
    end

    initial idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/vfa_pkg.sv
sv/vfa_sqrt_stage.sv
sv/vfa_div_stage.sv
sv/vector3_fixed_point_alu.sv
sv/vfa_checker.sv
verif/tb_vector3_fixed_point_alu.sv
